>>> design/lz4bd_pkg.sv
// ----------------------------------------------------------------------------
// lz4bd_pkg: shared types and constants
// Parser phases, per-item request to the history stage, and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lz4bd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_LITEXT,
    PH_LITERAL,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATEXT,
    PH_COPY
  } phase_t;

  localparam int unsigned HEADER_BYTES = 5;
  localparam logic [3:0]  NIBBLE_ESC   = 4'hf;
  localparam logic [7:0]  EXT_CONT     = 8'hff;
  localparam int unsigned MIN_MATCH    = 4;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // output queue
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_IW    = 2;

  // one accepted item, as handed from the parser to the history stage
  typedef struct packed {
    logic       accepted;
    logic       wr;        // item produces a byte that goes into history
    logic       is_copy;   // byte comes from history, not from the stream
    logic [7:0] lit_byte;
    logic       run_last;
    logic       done;
    logic       bad;
  } hist_req_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_done;
    logic       bad_offset;
  } result_t;

endpackage

`default_nettype wire

>>> design/lz4bd_ctrl.sv
// ----------------------------------------------------------------------------
// lz4bd_ctrl: sequence parser
// Walks header, token, length extensions, literals, offset and match copy;
// issues history read/write addresses for each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4bd_ctrl #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned AW            = 16,
  parameter int unsigned PW            = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic             kind,
  input  wire logic [7:0]       in_byte,
  input  wire logic             is_last,
  output lz4bd_pkg::hist_req_t  req,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] PROD_MAX = PW'(HISTORY_DEPTH);

  lz4bd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    hc_r, hc_nxt;
  logic [3:0]    nib_r, nib_nxt;
  logic [CW-1:0] ll_r, ll_nxt;
  logic [CW-1:0] ml_r, ml_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] prod_r, prod_nxt;

  logic [CW:0]   ll_add, ml_add;
  logic [CW+1:0] ml_add4;
  logic [CW-1:0] ll_dec, ml_dec;
  logic [AW:0]   off_w, wp_w;
  logic [15:0]   off_full;
  logic [AW-1:0] wp_inc;
  logic [PW-1:0] prod_inc;

  always_comb begin
    ll_add   = {1'b0, ll_r} + (CW+1)'(in_byte);
    ml_add   = {1'b0, ml_r} + (CW+1)'(in_byte);
    ml_add4  = (CW+2)'(ml_r) + (CW+2)'(in_byte) + (CW+2)'(lz4bd_pkg::MIN_MATCH);
    ll_dec   = (ll_r == '0) ? '0 : ll_r - CW'(1);
    ml_dec   = (ml_r == '0) ? '0 : ml_r - CW'(1);
    wp_inc   = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
    prod_inc = (prod_r == PROD_MAX) ? prod_r : prod_r + PW'(1);
    off_full = {in_byte, off_r[7:0]};
    // offset is known not to exceed the window here
    off_w    = (AW+1)'(off_r);
    wp_w     = {1'b0, wp_r};
    rd_addr  = (wp_w >= off_w) ? AW'(wp_w - off_w) : AW'(wp_w + DEPTH_W - off_w);
    wr_addr  = wp_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    nib_nxt   = nib_r;
    ll_nxt    = ll_r;
    ml_nxt    = ml_r;
    off_nxt   = off_r;
    wp_nxt    = wp_r;
    prod_nxt  = prod_r;
    req       = '0;
    req.lit_byte = in_byte;

    if (kind == lz4bd_pkg::KIND_TICK) begin
      if (phase_r == lz4bd_pkg::PH_COPY) begin
        req.wr      = 1'b1;
        req.is_copy = 1'b1;
        wp_nxt      = wp_inc;
        prod_nxt    = prod_inc;
        ml_nxt      = ml_dec;
        if (ml_dec == '0) begin
          req.run_last = 1'b1;
          phase_nxt    = lz4bd_pkg::PH_TOKEN;
        end
      end
    end else if (phase_r != lz4bd_pkg::PH_COPY) begin
      req.accepted = 1'b1;
      unique case (phase_r)
        lz4bd_pkg::PH_HEADER: begin
          if (is_last) begin
            req.done = 1'b1;
          end else if (hc_r >= 3'(lz4bd_pkg::HEADER_BYTES - 1)) begin
            hc_nxt    = '0;
            phase_nxt = lz4bd_pkg::PH_TOKEN;
          end else begin
            hc_nxt = hc_r + 3'd1;
          end
        end
        lz4bd_pkg::PH_TOKEN: begin
          nib_nxt = in_byte[3:0];
          ll_nxt  = CW'(in_byte[7:4]);
          if (is_last) begin
            req.done = 1'b1;
          end else if (in_byte[7:4] == lz4bd_pkg::NIBBLE_ESC) begin
            phase_nxt = lz4bd_pkg::PH_LITEXT;
          end else if (in_byte[7:4] == 4'd0) begin
            phase_nxt = lz4bd_pkg::PH_OFF_LO;
          end else begin
            phase_nxt = lz4bd_pkg::PH_LITERAL;
          end
        end
        lz4bd_pkg::PH_LITEXT: begin
          ll_nxt = ll_add[CW] ? CNT_MAX : ll_add[CW-1:0];
          if (is_last) begin
            req.done = 1'b1;
          end else if (in_byte != lz4bd_pkg::EXT_CONT) begin
            phase_nxt = lz4bd_pkg::PH_LITERAL;
          end
        end
        lz4bd_pkg::PH_LITERAL: begin
          req.wr   = 1'b1;
          wp_nxt   = wp_inc;
          prod_nxt = prod_inc;
          ll_nxt   = ll_dec;
          req.run_last = (ll_dec == '0);
          if (is_last) begin
            req.done = 1'b1;
          end else if (ll_dec == '0) begin
            phase_nxt = lz4bd_pkg::PH_OFF_LO;
          end
        end
        lz4bd_pkg::PH_OFF_LO: begin
          off_nxt = {8'd0, in_byte};
          if (is_last) begin
            req.done = 1'b1;
          end else begin
            phase_nxt = lz4bd_pkg::PH_OFF_HI;
          end
        end
        lz4bd_pkg::PH_OFF_HI: begin
          off_nxt = off_full;
          if (is_last) begin
            req.done = 1'b1;
          end else if (off_full == '0 || 17'(off_full) > 17'(prod_r)) begin
            req.bad  = 1'b1;
            req.done = 1'b1;
          end else if (nib_r == lz4bd_pkg::NIBBLE_ESC) begin
            ml_nxt    = CW'(lz4bd_pkg::NIBBLE_ESC);
            phase_nxt = lz4bd_pkg::PH_MATEXT;
          end else begin
            ml_nxt    = CW'(nib_r) + CW'(lz4bd_pkg::MIN_MATCH);
            phase_nxt = lz4bd_pkg::PH_COPY;
          end
        end
        lz4bd_pkg::PH_MATEXT: begin
          ml_nxt = ml_add[CW] ? CNT_MAX : ml_add[CW-1:0];
          if (is_last) begin
            req.done = 1'b1;
          end else if (in_byte != lz4bd_pkg::EXT_CONT) begin
            ml_nxt    = (ml_add4[CW+1:CW] != 2'd0) ? CNT_MAX : ml_add4[CW-1:0];
            phase_nxt = lz4bd_pkg::PH_COPY;
          end
        end
        lz4bd_pkg::PH_COPY: begin
          // unreachable: bytes are refused during a copy
          req.accepted = 1'b0;
        end
      endcase

      // block end: back to header, window emptied
      if (req.done) begin
        phase_nxt = lz4bd_pkg::PH_HEADER;
        hc_nxt    = '0;
        nib_nxt   = '0;
        ll_nxt    = '0;
        ml_nxt    = '0;
        off_nxt   = '0;
        wp_nxt    = '0;
        prod_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lz4bd_pkg::PH_HEADER;
      hc_r    <= '0;
      nib_r   <= '0;
      ll_r    <= '0;
      ml_r    <= '0;
      off_r   <= '0;
      wp_r    <= '0;
      prod_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      nib_r   <= nib_nxt;
      ll_r    <= ll_nxt;
      ml_r    <= ml_nxt;
      off_r   <= off_nxt;
      wp_r    <= wp_nxt;
      prod_r  <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lz4bd_hist.sv
// ----------------------------------------------------------------------------
// lz4bd_hist: history window stage
// Synchronous history RAM; the stage after acceptance picks up read data,
// forwards the byte still being written, writes it back and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4bd_hist #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned AW            = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_v,
  input  wire lz4bd_pkg::hist_req_t  req,
  input  wire logic [AW-1:0]         rd_addr,
  input  wire logic [AW-1:0]         wr_addr,
  output logic                       res_v,
  output lz4bd_pkg::result_t         res
);

  logic [7:0] mem [HISTORY_DEPTH];

  logic                 s1_v_r;
  lz4bd_pkg::hist_req_t s1_req_r;
  logic [AW-1:0]        s1_wa_r;
  logic [7:0]           rd_q_r;
  logic                 fwd_hit_r;
  logic [7:0]           fwd_byte_r;
  logic                 s1_wr;
  logic [7:0]           wdata;

  always_comb begin
    s1_wr = s1_v_r & s1_req_r.wr;
    if (!s1_req_r.is_copy) begin
      wdata = s1_req_r.lit_byte;
    end else if (fwd_hit_r) begin
      wdata = fwd_byte_r;
    end else begin
      wdata = rd_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_wa_r] <= wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // a read that hits the entry being written this cycle takes the new byte
  always_ff @(posedge clk) begin
    fwd_hit_r  <= s1_wr && (s1_wa_r == rd_addr);
    fwd_byte_r <= wdata;
    s1_req_r   <= req;
    s1_wa_r    <= wr_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= req_v;
    end
  end

  always_comb begin
    res_v          = s1_v_r;
    res.accepted   = s1_req_r.accepted;
    res.out_valid  = s1_req_r.wr;
    res.out_byte   = s1_req_r.wr ? wdata : 8'd0;
    res.run_last   = s1_req_r.run_last;
    res.block_done = s1_req_r.done;
    res.bad_offset = s1_req_r.bad;
  end

endmodule

`default_nettype wire

>>> design/lz4bd_outq.sv
// ----------------------------------------------------------------------------
// lz4bd_outq: result queue
// Three-entry queue between the history stage and the result channel; also
// produces the input-side credit.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4bd_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lz4bd_pkg::result_t  push_data,
  input  wire logic                pop,
  output logic                     can_take,
  output logic                     q_valid,
  output lz4bd_pkg::result_t       q_head
);

  localparam int unsigned QD = lz4bd_pkg::OQ_DEPTH;
  localparam int unsigned IW = lz4bd_pkg::OQ_IW;

  lz4bd_pkg::result_t ent_r [QD];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW:0]   used;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(QD - 1)) ? '0 : i + IW'(1);
  endfunction

  always_comb begin
    head_nxt = pop  ? idx_inc(head_r) : head_r;
    tail_nxt = push ? idx_inc(tail_r) : tail_r;
    cnt_nxt  = cnt_r + IW'(push) - IW'(pop);
    // one result in the history stage plus one more accepted now must fit
    used     = (IW+1)'(cnt_r) + (IW+1)'(push);
    can_take = used < (IW+1)'(QD);
    q_valid  = cnt_r != '0;
    q_head   = ent_r[head_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lz4_block_decompressor.sv
// ----------------------------------------------------------------------------
// lz4_block_decompressor: LZ4 block decoder, one item per cycle
// Parses a 5-byte header and LZ4 sequences from a byte stream, emits literals
// as they arrive and copies matches from a history window on drain ticks.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready   | tdata: in_byte; tuser: kind;
//          |     |                         | tlast: is_last
//  out_    | out | out_tvalid / out_tready | tdata: out_byte; tuser: accepted,
//          |     |                         | out_valid, block_done, bad_offset;
//          |     |                         | tlast: run_last
//
// Every input transaction (byte or drain tick) yields exactly one output
// transaction, through the history stage register and the output queue. One
// input transaction per cycle is sustained, copy ticks included: the history
// RAM read port is registered and a byte being written back is forwarded.
// Reset (rst_n low, synchronous) returns the parser to the header phase with
// an empty window; history contents need no clearing.
// in_tready drops only when the three-entry output queue, together with the
// result in flight, is full because out_tready is held low.
// ----------------------------------------------------------------------------
`default_nettype none

module lz4_block_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] in_byte
  input  wire logic [0:0] in_tuser,    // [0] kind: 0 byte, 1 drain tick
  input  wire logic       in_tlast,    // is_last

  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic [3:0]      out_tuser,   // [0] accepted, [1] out_valid,
                                       // [2] block_done, [3] bad_offset
  output logic            out_tlast    // run_last
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);

  logic                 take;
  lz4bd_pkg::hist_req_t req;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 res_v;
  lz4bd_pkg::result_t   res;
  logic                 can_take;
  logic                 q_valid;
  lz4bd_pkg::result_t   q_head;
  logic                 pop;

  assign in_tready = can_take;
  assign take      = in_tvalid & can_take;
  assign pop       = q_valid & out_tready;

  // stage 0: parser state updates on the transaction itself
  lz4bd_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .AW            (AW),
    .PW            (PW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .kind    (in_tuser[0]),
    .in_byte (in_tdata),
    .is_last (in_tlast),
    .req     (req),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  // stage 1: history read data, write-back, result formation
  lz4bd_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_v   (take),
    .req     (req),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .res_v   (res_v),
    .res     (res)
  );

  // result queue decouples the output channel
  lz4bd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .pop       (pop),
    .can_take  (can_take),
    .q_valid   (q_valid),
    .q_head    (q_head)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = q_head.out_byte;
  assign out_tuser  = {q_head.bad_offset, q_head.block_done, q_head.out_valid,
                       q_head.accepted};
  assign out_tlast  = q_head.run_last;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lz4_block_decompressor
// Builds compressed streams (clean blocks, bad offsets, blocks cut short and
// random noise), predicts every result with a behavioral LZ4 decoder and
// compares each output transaction with the oldest expectation. Both stream
// sides stall at random.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned CNT_WIDTH  = 32;
  localparam longint unsigned CNT_MAX = 64'h0000_0000_ffff_ffff;
  localparam int unsigned RANDOM_ITEMS = 1050;

  typedef enum int {BLK_CLEAN, BLK_BAD_OFFSET, BLK_CUT} blk_mode_t;

  // one input transaction: kind (tuser), byte (tdata), end-of-block (tlast)
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } comp_item_t;

  // input transaction paired with the result it must produce
  typedef struct packed {
    comp_item_t         item;
    lz4bd_pkg::result_t want;
  } stream_entry_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  lz4_block_decompressor #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .COUNT_WIDTH  (CNT_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder state. The stream generator steps it as it builds the
  // stream, so it always knows where the decoder stands (copy in progress,
  // bytes produced so far) and can pick legal offsets and drain counts.
  // --------------------------------------------------------------------------
  lz4bd_pkg::phase_t dec_phase;
  int unsigned       dec_hdr_cnt;
  logic [3:0]        dec_match_nib;
  longint unsigned   dec_lit_left;
  longint unsigned   dec_mat_left;
  logic [15:0]       dec_offset;
  logic [7:0]        hist_mem [0:HIST_DEPTH-1];
  logic [15:0]       dec_wr_ptr;
  int unsigned       dec_produced;

  stream_entry_t      stream_q[$];    // input transactions not yet offered
  lz4bd_pkg::result_t due_results[$]; // results owed for accepted inputs
  int                 errors;
  int                 useful;         // inputs that do something (not ignored)
  int                 cut_left;       // accepted bytes until a forced early end
  bit                 blk_over;
  bit                 calm [2];       // per side: stretch with no idling

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b);
    if (a >= CNT_MAX || b > CNT_MAX - a) return CNT_MAX;
    return a + b;
  endfunction

  function automatic void hist_put(input logic [7:0] b);
    hist_mem[dec_wr_ptr] = b;
    dec_wr_ptr = dec_wr_ptr + 16'd1;
    if (dec_produced < HIST_DEPTH) dec_produced++;
  endfunction

  // back to header phase with an empty window; history bytes stay but the
  // produced count guards every later read
  function automatic void end_block();
    dec_phase     = lz4bd_pkg::PH_HEADER;
    dec_hdr_cnt   = 0;
    dec_match_nib = '0;
    dec_lit_left  = 0;
    dec_mat_left  = 0;
    dec_offset    = '0;
    dec_wr_ptr    = '0;
    dec_produced  = 0;
  endfunction

  function automatic lz4bd_pkg::result_t lz4_decode_step(input comp_item_t it);
    lz4bd_pkg::result_t r;
    logic [15:0]        rd_idx;
    r = '0;
    if (it.kind == lz4bd_pkg::KIND_TICK) begin
      // drain tick: one copied byte if a match is pending, else nothing
      if (dec_phase == lz4bd_pkg::PH_COPY) begin
        rd_idx = dec_wr_ptr - dec_offset;
        r.out_valid = 1'b1;
        r.out_byte  = hist_mem[rd_idx];
        hist_put(hist_mem[rd_idx]);
        if (dec_mat_left > 0) dec_mat_left--;
        if (dec_mat_left == 0) begin
          r.run_last = 1'b1;
          dec_phase  = lz4bd_pkg::PH_TOKEN;
        end
      end
    end else if (dec_phase != lz4bd_pkg::PH_COPY) begin
      r.accepted = 1'b1;
      case (dec_phase)
        lz4bd_pkg::PH_HEADER: begin
          if (dec_hdr_cnt >= lz4bd_pkg::HEADER_BYTES - 1) begin
            dec_hdr_cnt = 0;
            dec_phase   = lz4bd_pkg::PH_TOKEN;
          end else begin
            dec_hdr_cnt++;
          end
        end
        lz4bd_pkg::PH_TOKEN: begin
          dec_match_nib = it.data[3:0];
          dec_lit_left  = 64'(it.data[7:4]);
          if (it.data[7:4] == lz4bd_pkg::NIBBLE_ESC) dec_phase = lz4bd_pkg::PH_LITEXT;
          else if (it.data[7:4] == 4'd0)            dec_phase = lz4bd_pkg::PH_OFF_LO;
          else                                      dec_phase = lz4bd_pkg::PH_LITERAL;
        end
        lz4bd_pkg::PH_LITEXT: begin
          dec_lit_left = sat_add(dec_lit_left, 64'(it.data));
          if (it.data != lz4bd_pkg::EXT_CONT) dec_phase = lz4bd_pkg::PH_LITERAL;
        end
        lz4bd_pkg::PH_LITERAL: begin
          hist_put(it.data);
          r.out_valid = 1'b1;
          r.out_byte  = it.data;
          if (dec_lit_left > 0) dec_lit_left--;
          if (dec_lit_left == 0) begin
            r.run_last = 1'b1;
            dec_phase  = lz4bd_pkg::PH_OFF_LO;
          end
        end
        lz4bd_pkg::PH_OFF_LO: begin
          dec_offset = {8'h00, it.data};
          dec_phase  = lz4bd_pkg::PH_OFF_HI;
        end
        lz4bd_pkg::PH_OFF_HI: begin
          dec_offset[15:8] = it.data;
          if (!it.last) begin
            if (dec_offset == 0 || 32'(dec_offset) > dec_produced) begin
              r.bad_offset = 1'b1;
              r.block_done = 1'b1;
              end_block();
            end else if (dec_match_nib == lz4bd_pkg::NIBBLE_ESC) begin
              dec_mat_left = 64'(lz4bd_pkg::NIBBLE_ESC);
              dec_phase    = lz4bd_pkg::PH_MATEXT;
            end else begin
              dec_mat_left = 64'(dec_match_nib) + 64'(lz4bd_pkg::MIN_MATCH);
              dec_phase    = lz4bd_pkg::PH_COPY;
            end
          end
        end
        lz4bd_pkg::PH_MATEXT: begin
          dec_mat_left = sat_add(dec_mat_left, 64'(it.data));
          if (it.data != lz4bd_pkg::EXT_CONT) begin
            dec_mat_left = sat_add(dec_mat_left, 64'(lz4bd_pkg::MIN_MATCH));
            dec_phase    = lz4bd_pkg::PH_COPY;
          end
        end
        default: ;
      endcase
      // a byte marked last ends the block wherever it lands
      if (it.last) begin
        r.block_done = 1'b1;
        end_block();
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stream generation
  // --------------------------------------------------------------------------
  task automatic push_item(input logic kind, input logic [7:0] data, input logic last);
    stream_entry_t e;
    logic          fin;
    fin = last;
    // early-end injection counts only bytes the decoder will consume
    if (kind == lz4bd_pkg::KIND_BYTE && dec_phase != lz4bd_pkg::PH_COPY &&
        cut_left >= 0) begin
      if (cut_left == 0) fin = 1'b1;
      cut_left--;
    end
    e.item = {kind, data, fin};
    e.want = lz4_decode_step(e.item);
    if (e.want.block_done) blk_over = 1'b1;
    if (e.want.accepted || e.want.out_valid) useful++;
    stream_q.push_back(e);
  endtask

  // 0xff bytes continue, the first byte below 0xff closes the length
  task automatic push_len_ext(input int rem);
    while (rem >= 255 && !blk_over) begin
      push_item(lz4bd_pkg::KIND_BYTE, lz4bd_pkg::EXT_CONT, 1'b0);
      rem -= 255;
    end
    if (!blk_over) push_item(lz4bd_pkg::KIND_BYTE, 8'(rem), 1'b0);
  endtask

  // ticks until the copy is over; a refused byte slips in now and then
  task automatic drain_copy();
    while (dec_phase == lz4bd_pkg::PH_COPY) begin
      if ($urandom_range(0, 9) == 0)
        push_item(lz4bd_pkg::KIND_BYTE, 8'($urandom), 1'($urandom));
      else
        push_item(lz4bd_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  function automatic int pick_lit_len();
    int r;
    r = $urandom_range(0, 63);
    if (r == 0) return 270;                     // extension 0xff then 0x00
    if (r < 3)  return $urandom_range(15, 300);
    if (r < 6)  return 15;                      // extension byte of zero
    return $urandom_range(0, 14);
  endfunction

  function automatic int pick_match_len();
    int r;
    r = $urandom_range(0, 63);
    if (r == 0) return 274;
    if (r < 3)  return $urandom_range(19, 300);
    if (r < 8)  return 19;
    return $urandom_range(4, 18);
  endfunction

  task automatic gen_sequence(input int nlit, input int mlen, input bit final_seq,
                              input bit bad_off);
    int         mcode;
    int         lim;
    int         off;
    logic [3:0] lit_nib;
    logic [3:0] mat_nib;
    mcode   = mlen - lz4bd_pkg::MIN_MATCH;
    lit_nib = (nlit >= 15) ? lz4bd_pkg::NIBBLE_ESC : 4'(nlit);
    mat_nib = (mcode >= 15) ? lz4bd_pkg::NIBBLE_ESC : 4'(mcode);
    push_item(lz4bd_pkg::KIND_BYTE, {lit_nib, mat_nib}, 1'b0);
    if (nlit >= 15) push_len_ext(nlit - 15);
    for (int i = 0; i < nlit && !blk_over; i++)
      push_item(lz4bd_pkg::KIND_BYTE, 8'($urandom), final_seq && i == nlit - 1);
    if (final_seq || blk_over) return;

    lim = (dec_produced > 65535) ? 65535 : dec_produced;
    if (bad_off || lim == 0) begin
      off = ($urandom_range(0, 1) == 0 || lim > 65530) ? 0 : lim + $urandom_range(1, 4);
    end else if ($urandom_range(0, 3) == 0) begin
      off = $urandom_range(1, lim);
    end else begin
      off = $urandom_range(1, (lim < 4) ? lim : 4);  // short offsets overlap
    end
    push_item(lz4bd_pkg::KIND_BYTE, off[7:0], 1'b0);
    if (!blk_over) push_item(lz4bd_pkg::KIND_BYTE, off[15:8], 1'b0);
    if (blk_over) return;
    if (mcode >= 15) push_len_ext(mcode - 15);
    drain_copy();
    if (!blk_over && $urandom_range(0, 7) == 0)
      push_item(lz4bd_pkg::KIND_TICK, 8'($urandom), 1'b0);
  endtask

  task automatic gen_block(input blk_mode_t mode);
    int nseq;
    int nlit;
    blk_over = 1'b0;
    cut_left = (mode == BLK_CUT) ? $urandom_range(0, 60) : -1;
    for (int i = 0; i < lz4bd_pkg::HEADER_BYTES && !blk_over; i++)
      push_item(lz4bd_pkg::KIND_BYTE, 8'($urandom), 1'b0);
    nseq = $urandom_range((mode == BLK_BAD_OFFSET) ? 1 : 0, 4);
    for (int s = 0; s < nseq && !blk_over; s++) begin
      nlit = pick_lit_len();
      if (dec_produced == 0 && nlit == 0) nlit = 1;
      gen_sequence(nlit, pick_match_len(), 1'b0, mode == BLK_BAD_OFFSET && s == nseq - 1);
    end
    if (!blk_over) begin
      nlit = pick_lit_len();
      gen_sequence((nlit == 0) ? 1 : nlit, pick_match_len(), 1'b1, 1'b0);
    end
  endtask

  // random transactions, then drain and force an end so the next block
  // starts from the header again
  task automatic gen_noise();
    cut_left = -1;
    if ($urandom_range(0, 1) == 1)
      repeat (lz4bd_pkg::HEADER_BYTES)
        push_item(lz4bd_pkg::KIND_BYTE, 8'($urandom), 1'b0);
    repeat ($urandom_range(1, 30))
      push_item(($urandom_range(0, 3) == 0) ? lz4bd_pkg::KIND_TICK : lz4bd_pkg::KIND_BYTE,
                8'($urandom), $urandom_range(0, 15) == 0);
    drain_copy();
    if (dec_phase != lz4bd_pkg::PH_HEADER || dec_hdr_cnt != 0)
      push_item(lz4bd_pkg::KIND_BYTE, 8'($urandom), 1'b1);
  endtask

  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 63) == 0) calm[side] = !calm[side];
    return calm[side] ? 0 : $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued inputs; an accepted input moves its expectation to
  // the result store, then the idle gap for the next one is drawn.
  // --------------------------------------------------------------------------
  stream_entry_t      in_cur;
  lz4bd_pkg::result_t in_want;
  int                 in_wait;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = draw_gap(0);
    end else begin
      if (in_tvalid && in_tready) due_results.push_back(in_want);
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_cur = stream_q.pop_front();
          in_want = in_cur.want;
          in_tdata  <= in_cur.item.data;
          in_tuser  <= in_cur.item.kind;
          in_tlast  <= in_cur.item.last;
          in_tvalid <= 1'b1;
          in_wait = draw_gap(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transaction field by field, then holds
  // out_tready low for a drawn number of cycles.
  // --------------------------------------------------------------------------
  lz4bd_pkg::result_t seen;
  lz4bd_pkg::result_t want;
  int                 out_wait;

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tuser[0], out_tuser[1], out_tdata, out_tlast, out_tuser[2], out_tuser[3]};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, got %h", $time, seen);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("accepted",   8'(want.accepted),   8'(seen.accepted));
          check_field("out_valid",  8'(want.out_valid),  8'(seen.out_valid));
          check_field("out_byte",   want.out_byte,       seen.out_byte);
          check_field("run_last",   8'(want.run_last),   8'(seen.run_last));
          check_field("block_done", 8'(want.block_done), 8'(seen.block_done));
          check_field("bad_offset", 8'(want.bad_offset), 8'(seen.bad_offset));
        end
        out_wait = draw_gap(1);
      end
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    errors = 0;
    useful = 0;
    end_block();
    cut_left = -1;
    blk_over = 1'b0;

    // directed: idle tick, end inside the header, overlapping copy with a
    // refused byte, idle tick after the copy, normal end, offset past history
    push_item(lz4bd_pkg::KIND_TICK, 8'hff, 1'b1);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h00, 1'b1);
    repeat (lz4bd_pkg::HEADER_BYTES) push_item(lz4bd_pkg::KIND_BYTE, 8'hff, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h20, 1'b0);   // two literals, match of four
    push_item(lz4bd_pkg::KIND_BYTE, 8'h00, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'hff, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h01, 1'b0);   // offset one repeats the last byte
    push_item(lz4bd_pkg::KIND_BYTE, 8'h00, 1'b0);
    push_item(lz4bd_pkg::KIND_TICK, 8'h00, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h5a, 1'b1);   // refused: copy in progress
    repeat (3) push_item(lz4bd_pkg::KIND_TICK, 8'h00, 1'b0);
    push_item(lz4bd_pkg::KIND_TICK, 8'h00, 1'b0);   // nothing to copy any more
    push_item(lz4bd_pkg::KIND_BYTE, 8'h10, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h80, 1'b1);   // literal run ends on last
    repeat (lz4bd_pkg::HEADER_BYTES) push_item(lz4bd_pkg::KIND_BYTE, 8'h00, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h10, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h7f, 1'b0);
    push_item(lz4bd_pkg::KIND_BYTE, 8'h02, 1'b0);   // two bytes back, only one produced
    push_item(lz4bd_pkg::KIND_BYTE, 8'h00, 1'b0);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       gen_block(BLK_CLEAN);
      else if (pick == 7) gen_block(BLK_BAD_OFFSET);
      else if (pick == 8) gen_block(BLK_CUT);
      else                gen_noise();
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // results pass the history stage and the output queue; catch any stray extras
    repeat (20) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
